@@ rtl/core/skt_pkg.sv @@
// Shared constants and types for the sorted key table.
package skt_pkg;

    // Field widths of the stream beats.
    localparam int CMD_W     = 3;
    localparam int KEY_W     = 64;
    localparam int PAYLOAD_W = 32;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 6;

    // Packed beat widths, padded to whole bytes.
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 112;
    localparam int M_PAD_W   = M_TDATA_W - (POS_W + KEY_W + PAYLOAD_W + COUNT_W);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd3;

    // One finished result, before it moves to the output register.
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [POS_W-1:0]     found_position;
        logic [KEY_W-1:0]     found_key;
        logic [PAYLOAD_W-1:0] found_payload;
    } result_t;

endpackage

@@ rtl/core/sorted_key_table_core.sv @@
// Top level of the sorted key table: command sequencer, entry store and result register.
//
// The block keeps up to DEPTH entries (key and payload) in ascending unsigned key order
// and serves one command at a time: insert, delete at position, update at position,
// find key (highest matching index) and read position. Each command beat gives exactly
// one result beat that also reports the entry count. All entries live in one memory
// with a single write port and a single registered read port, and the sequencer moves
// at most one entry per cycle through it, which sets the time per command. An insert
// runs a forward scan up to the place of the new entry, then a shift of the larger
// keys, which together read every entry; a delete at position p moves the entries
// above p down, a find scans backward from the top, and read, update, a full table
// or a bad position need no scan. The input is ready only while no command is in
// progress; a result waiting in the output register does not block the next command.
// No clearing pass runs after reset.
module sorted_key_table_core #(
    parameter int DEPTH        = 32,
    parameter int KEY_BITS     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Command channel.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: key [63:0], payload [95:64], position [100:96], zero pad.
    input  logic [skt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: cmd [2:0].
    input  logic [skt_pkg::CMD_W-1:0]      s_axis_tuser,
    // Result channel.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: found_position [4:0], found_key [68:5], found_payload [100:69],
    //        entry_count [106:101], zero pad.
    output logic [skt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: status [1:0].
    output logic [skt_pkg::STATUS_W-1:0]   m_axis_tuser
);

    import skt_pkg::*;

    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EXT_W = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int PSW   = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
    localparam int EW    = KEY_BITS + PSW;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_SCAN      = 8'b0000_0010,
        ST_MOVE_UP   = 8'b0000_0100,
        ST_WRITE_NEW = 8'b0000_1000,
        ST_MOVE_DN   = 8'b0001_0000,
        ST_FIND      = 8'b0010_0000,
        ST_READ      = 8'b0100_0000,
        ST_POST      = 8'b1000_0000
    } state_t;

    // Widening helpers for index and field conversions.
    function automatic logic [EXT_W-1:0] ext_idx(input logic [IW-1:0] idx);
        ext_idx          = '0;
        ext_idx[IW-1:0]  = idx;
    endfunction

    function automatic logic [POS_W-1:0] pos_of(input logic [IW-1:0] idx);
        logic [EXT_W-1:0] w;
        w      = ext_idx(idx);
        pos_of = w[POS_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] key_out(input logic [KEY_BITS-1:0] k);
        key_out                = '0;
        key_out[KEY_BITS-1:0]  = k;
    endfunction

    function automatic logic [PAYLOAD_W-1:0] pay_out(input logic [PSW-1:0] p);
        pay_out           = '0;
        pay_out[PSW-1:0]  = p;
    endfunction

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [PSW-1:0]        pay_reg, pay_next;
    logic [IW-1:0]         addr_reg, addr_next;
    logic                  iss_reg, iss_next;
    logic                  lag_vld_reg, lag_vld_next;
    logic [IW-1:0]         lag_addr_reg, lag_addr_next;
    logic [IW-1:0]         at_reg, at_next;
    result_t               res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [STATUS_W-1:0]   m_user_reg, m_user_next;

    logic                  mem_wr_en;
    logic [IW-1:0]         mem_wr_addr;
    logic [EW-1:0]         mem_wr_data;
    logic                  mem_rd_en;
    logic [IW-1:0]         mem_rd_addr;
    logic [EW-1:0]         mem_rd_data;

    logic [KEY_BITS-1:0]   rd_key;
    logic [PSW-1:0]        rd_pay;
    logic [KEY_BITS-1:0]   in_key;
    logic [PSW-1:0]        in_pay;
    logic [POS_W-1:0]      in_pos;
    logic [EXT_W-1:0]      in_pos_w;
    logic [IW-1:0]         in_pos_idx;
    logic [EXT_W-1:0]      count_w;
    logic [CW-1:0]         count_m1;
    logic [IW-1:0]         count_m1_idx;
    logic [EXT_W-1:0]      addr_w;
    logic                  s_accept;
    logic                  out_free;

    // Field unpacking and index widening.
    assign in_key     = s_axis_tdata[KEY_BITS-1:0];
    assign in_pay     = s_axis_tdata[KEY_W+PSW-1:KEY_W];
    assign in_pos     = s_axis_tdata[KEY_W+PAYLOAD_W+POS_W-1:KEY_W+PAYLOAD_W];
    assign rd_key     = mem_rd_data[EW-1:PSW];
    assign rd_pay     = mem_rd_data[PSW-1:0];

    always_comb begin
        in_pos_w               = '0;
        in_pos_w[POS_W-1:0]    = in_pos;
        count_w                = '0;
        count_w[CW-1:0]        = count_reg;
    end

    assign in_pos_idx   = in_pos_w[IW-1:0];
    assign count_m1     = count_reg - CW'(1);
    assign count_m1_idx = count_m1[IW-1:0];
    assign addr_w       = ext_idx(addr_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && (state_reg == ST_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Command sequencer.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        addr_next     = addr_reg;
        iss_next      = iss_reg;
        at_next       = at_reg;
        res_next      = res_reg;
        lag_vld_next  = 1'b0;
        lag_addr_next = addr_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = at_reg;
        mem_wr_data   = {key_reg, pay_reg};
        mem_rd_en     = 1'b0;
        mem_rd_addr   = addr_reg;

        // A taken result frees the output register.
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    key_next = in_key;
                    pay_next = in_pay;
                    res_next = '0;
                    priority if (s_axis_tuser == CMD_INSERT) begin
                        if (count_reg == CW'(DEPTH)) begin
                            res_next.status = STAT_FULL;
                            state_next      = ST_POST;
                        end else begin
                            addr_next  = '0;
                            state_next = ST_SCAN;
                        end
                    end else if (s_axis_tuser == CMD_DELETE) begin
                        if (in_pos_w >= count_w) begin
                            res_next.status = STAT_RANGE;
                            state_next      = ST_POST;
                        end else begin
                            iss_next   = (in_pos_w + EXT_W'(1)) < count_w;
                            addr_next  = in_pos_idx + IW'(1);
                            state_next = ST_MOVE_DN;
                        end
                    end else if (s_axis_tuser == CMD_UPDATE) begin
                        if (in_pos_w >= count_w) begin
                            res_next.status = STAT_RANGE;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = in_pos_idx;
                            mem_wr_data = {in_key, in_pay};
                        end
                        state_next = ST_POST;
                    end else if (s_axis_tuser == CMD_FIND) begin
                        if (count_reg == '0) begin
                            res_next.status = STAT_NOT_FOUND;
                            state_next      = ST_POST;
                        end else begin
                            addr_next  = count_m1_idx;
                            iss_next   = 1'b1;
                            state_next = ST_FIND;
                        end
                    end else if (s_axis_tuser == CMD_READ) begin
                        if (in_pos_w >= count_w) begin
                            res_next.status = STAT_RANGE;
                            state_next      = ST_POST;
                        end else begin
                            mem_rd_en     = 1'b1;
                            mem_rd_addr   = in_pos_idx;
                            lag_vld_next  = 1'b1;
                            lag_addr_next = in_pos_idx;
                            state_next    = ST_READ;
                        end
                    end else begin
                        state_next = ST_POST;
                    end
                end
            end

            // Forward scan for the first key that is not smaller.
            ST_SCAN: begin
                if (lag_vld_reg && (rd_key >= key_reg)) begin
                    at_next    = lag_addr_reg;
                    addr_next  = count_m1_idx;
                    iss_next   = 1'b1;
                    state_next = ST_MOVE_UP;
                end else if (!lag_vld_reg && (addr_w >= count_w)) begin
                    at_next    = count_reg[IW-1:0];
                    state_next = ST_WRITE_NEW;
                end else if (addr_w < count_w) begin
                    mem_rd_en     = 1'b1;
                    lag_vld_next  = 1'b1;
                    lag_addr_next = addr_reg;
                    addr_next     = addr_reg + IW'(1);
                end
            end

            // Shift entries from the top down to the insert point, one per cycle.
            ST_MOVE_UP: begin
                if (lag_vld_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = lag_addr_reg + IW'(1);
                    mem_wr_data = mem_rd_data;
                end
                if (iss_reg) begin
                    mem_rd_en     = 1'b1;
                    lag_vld_next  = 1'b1;
                    lag_addr_next = addr_reg;
                    if (addr_reg == at_reg) begin
                        iss_next = 1'b0;
                    end else begin
                        addr_next = addr_reg - IW'(1);
                    end
                end else if (!lag_vld_reg) begin
                    state_next = ST_WRITE_NEW;
                end
            end

            // Place the new entry.
            ST_WRITE_NEW: begin
                mem_wr_en               = 1'b1;
                mem_wr_addr             = at_reg;
                count_next              = count_reg + CW'(1);
                res_next.status         = STAT_OK;
                res_next.found_position = pos_of(at_reg);
                res_next.found_key      = key_out(key_reg);
                res_next.found_payload  = pay_out(pay_reg);
                state_next              = ST_POST;
            end

            // Close the gap above the deleted entry.
            ST_MOVE_DN: begin
                if (lag_vld_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = lag_addr_reg - IW'(1);
                    mem_wr_data = mem_rd_data;
                end
                if (iss_reg) begin
                    mem_rd_en     = 1'b1;
                    lag_vld_next  = 1'b1;
                    lag_addr_next = addr_reg;
                    if (addr_w == (count_w - EXT_W'(1))) begin
                        iss_next = 1'b0;
                    end else begin
                        addr_next = addr_reg + IW'(1);
                    end
                end else if (!lag_vld_reg) begin
                    count_next = count_m1;
                    state_next = ST_POST;
                end
            end

            // Backward scan for the highest equal key.
            ST_FIND: begin
                if (lag_vld_reg && (rd_key == key_reg)) begin
                    res_next.status         = STAT_OK;
                    res_next.found_position = pos_of(lag_addr_reg);
                    res_next.found_key      = key_out(rd_key);
                    res_next.found_payload  = pay_out(rd_pay);
                    state_next              = ST_POST;
                end else if (iss_reg) begin
                    mem_rd_en     = 1'b1;
                    lag_vld_next  = 1'b1;
                    lag_addr_next = addr_reg;
                    if (addr_reg == '0) begin
                        iss_next = 1'b0;
                    end else begin
                        addr_next = addr_reg - IW'(1);
                    end
                end else if (!lag_vld_reg) begin
                    res_next.status = STAT_NOT_FOUND;
                    state_next      = ST_POST;
                end
            end

            ST_READ: begin
                res_next.status         = STAT_OK;
                res_next.found_position = pos_of(lag_addr_reg);
                res_next.found_key      = key_out(rd_key);
                res_next.found_payload  = pay_out(rd_pay);
                state_next              = ST_POST;
            end

            // Hand the result to the output register once it is free.
            ST_POST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{M_PAD_W{1'b0}}, count_w[COUNT_W-1:0],
                                    res_reg.found_payload, res_reg.found_key,
                                    res_reg.found_position};
                    m_user_next  = res_reg.status;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            iss_reg     <= 1'b0;
            lag_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            iss_reg     <= iss_next;
            lag_vld_reg <= lag_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        addr_reg     <= addr_next;
        lag_addr_reg <= lag_addr_next;
        at_reg       <= at_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    skt_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // The entry count never passes the table depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond table depth");

    // The store is written only while a command is being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !s_accept) |-> !mem_wr_en)
        else $error("store written while idle");

    // A placed entry raises the count by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE_NEW) |=> (count_reg == CW'($past(count_reg) + CW'(1))))
        else $error("insert did not raise the count by one");

    // The upward shift never writes at or below the insert point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOVE_UP && mem_wr_en) |-> (mem_wr_addr > at_reg))
        else $error("upward shift overwrote the insert point");

    // A result handed over appears on the output in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POST && out_free) |=> m_axis_tvalid)
        else $error("finished result not presented");

endmodule

@@ rtl/core/skt_mem.sv @@
// Entry store of the sorted key table: one write port and one registered read port.
module skt_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 96
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the sorted key table core.
`timescale 1ns / 1ps

module tb;
    import skt_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int CALM_ITEMS = 150;
    localparam int DRAIN_CYCLES = 80;

    // One command beat as the stimulus sees it.
    typedef struct {
        logic [CMD_W-1:0]     cmd;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic [POS_W-1:0]     pos;
    } table_cmd_t;

    // One result beat, split into its fields.
    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [POS_W-1:0]     position;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic [COUNT_W-1:0]   count;
    } table_reply_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // tdata: key [63:0], payload [95:64], position [100:96], zero pad.
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // tuser: cmd [2:0].
    logic [CMD_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // tdata: found_position [4:0], found_key [68:5], found_payload [100:69],
    //        entry_count [106:101], zero pad.
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // tuser: status [1:0].
    logic [STATUS_W-1:0] m_axis_tuser;

    sorted_key_table_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    table_cmd_t   pending_cmds[$];
    table_reply_t expected_replies[$];
    int total_items = 0;
    int items_accepted = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int recv_gap = 0;

    // Shadow of the table contents, updated as each command beat is accepted.
    logic [KEY_W-1:0]     shadow_keys[TABLE_DEPTH];
    logic [PAYLOAD_W-1:0] shadow_payloads[TABLE_DEPTH];
    int shadow_count = 0;

    // Running entry count as the stimulus is built, used to aim positions.
    int gen_count = 0;
    logic [KEY_W-1:0] key_pool[16];

    // Works out the reply for one command and updates the shadow table.
    function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                          input logic [KEY_W-1:0] key,
                                          input logic [PAYLOAD_W-1:0] payload,
                                          input logic [POS_W-1:0] pos);
        table_reply_t r;
        int at;
        int i;
        bit hit;
        r.status = STAT_OK;
        r.position = '0;
        r.key = '0;
        r.payload = '0;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    at = 0;
                    while (at < shadow_count && shadow_keys[at] < key)
                        at++;
                    for (i = shadow_count; i > at; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_payloads[i] = shadow_payloads[i-1];
                    end
                    shadow_keys[at] = key;
                    shadow_payloads[at] = payload;
                    shadow_count++;
                    r.position = at[POS_W-1:0];
                    r.key = key;
                    r.payload = payload;
                end
            end
            CMD_DELETE: begin
                if (pos >= shadow_count) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (i = int'(pos); i + 1 < shadow_count; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_payloads[i] = shadow_payloads[i+1];
                    end
                    shadow_count--;
                end
            end
            CMD_UPDATE: begin
                if (pos >= shadow_count) begin
                    r.status = STAT_RANGE;
                end else begin
                    shadow_keys[pos] = key;
                    shadow_payloads[pos] = payload;
                end
            end
            CMD_FIND: begin
                // Highest-indexed match wins.
                hit = 1'b0;
                i = shadow_count;
                while (i > 0 && !hit) begin
                    if (shadow_keys[i-1] == key) begin
                        hit = 1'b1;
                        r.position = POS_W'(i - 1);
                        r.key = shadow_keys[i-1];
                        r.payload = shadow_payloads[i-1];
                    end
                    i--;
                end
                if (!hit)
                    r.status = STAT_NOT_FOUND;
            end
            CMD_READ: begin
                if (pos >= shadow_count) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.position = pos;
                    r.key = shadow_keys[pos];
                    r.payload = shadow_payloads[pos];
                end
            end
            default: begin
                // Unused command codes leave the table alone.
            end
        endcase
        r.count = shadow_count[COUNT_W-1:0];
        expected_replies.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [KEY_W-1:0] exp_val,
                                        input logic [KEY_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val,
                     act_val);
            fail_count++;
        end
    endfunction

    // Percent chance per cycle that a side starts an idle burst; none near the end.
    function automatic int idle_odds();
        if (items_accepted >= total_items - CALM_ITEMS)
            return 0;
        case ((items_accepted / 120) % 4)
            0: return 0;
            1: return 8;
            2: return 25;
            default: return 12;
        endcase
    endfunction

    function automatic void push_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                     input logic [PAYLOAD_W-1:0] payload,
                                     input logic [POS_W-1:0] pos);
        table_cmd_t c;
        c.cmd = cmd;
        c.key = key;
        c.payload = payload;
        c.pos = pos;
        pending_cmds.push_back(c);
        if (cmd == CMD_INSERT && gen_count < TABLE_DEPTH)
            gen_count++;
        else if (cmd == CMD_DELETE && pos < gen_count)
            gen_count--;
    endfunction

    // Keys lean on a small pool so that duplicates and find hits are common.
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return key_pool[$urandom_range(0, 15)];
        else if (roll < 55)
            return '0;
        else if (roll < 60)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PAYLOAD_W-1:0] pick_payload();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        else if (roll < 10)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if (gen_count > 0 && $urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(0, gen_count - 1));
        return POS_W'($urandom_range(0, 31));
    endfunction

    // Command driver: presents queued beats, with random idle bursts.
    always @(posedge aclk) begin
        table_cmd_t c;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            send_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_command(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[95:64],
                              s_axis_tdata[100:96]);
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if ($urandom_range(0, 99) < idle_odds()) begin
                    send_gap <= $urandom_range(0, 12);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= c.cmd;
                    s_axis_tdata <= {3'b000, c.pos, c.payload, c.key};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each beat with the oldest expected reply.
    always @(posedge aclk) begin
        table_reply_t e;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: result beat with no command waiting, actual %h %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    fail_count++;
                end else begin
                    e = expected_replies.pop_front();
                    check_field("status", KEY_W'(e.status), KEY_W'(m_axis_tuser));
                    check_field("found_position", KEY_W'(e.position),
                                KEY_W'(m_axis_tdata[4:0]));
                    check_field("found_key", e.key, m_axis_tdata[68:5]);
                    check_field("found_payload", KEY_W'(e.payload),
                                KEY_W'(m_axis_tdata[100:69]));
                    check_field("entry_count", KEY_W'(e.count),
                                KEY_W'(m_axis_tdata[106:101]));
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_odds()) begin
                recv_gap <= $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int random_left;
        int seg_kind;
        int seg_len;
        int n;
        int roll;
        logic [CMD_W-1:0] op;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < 16; n++) begin
            if (n % 3 == 0)
                key_pool[n] = key_pool[n-1] + 1;
            else
                key_pool[n] = {$urandom, $urandom};
        end

        // Directed part: empty table, extremes, duplicates and bad positions.
        push_cmd(CMD_READ, '0, '0, 5'd0);
        push_cmd(CMD_DELETE, '0, '0, 5'd0);
        push_cmd(CMD_UPDATE, '1, '1, 5'd31);
        push_cmd(CMD_FIND, '0, '0, 5'd0);
        push_cmd(CMD_INSERT, '0, '0, 5'd0);
        push_cmd(CMD_INSERT, '1, '1, 5'd31);
        push_cmd(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h1234_5678, 5'd0);
        push_cmd(CMD_INSERT, '0, 32'hA5A5_5A5A, 5'd0);
        push_cmd(CMD_FIND, '0, '0, 5'd0);
        push_cmd(CMD_FIND, '1, '0, 5'd0);
        push_cmd(CMD_FIND, 64'h0000_0000_0000_0001, '0, 5'd0);
        push_cmd(CMD_READ, '0, '0, 5'd0);
        push_cmd(CMD_READ, '0, '0, 5'd3);
        push_cmd(CMD_READ, '0, '0, 5'd4);
        push_cmd(CMD_READ, '0, '0, 5'd31);
        // Update does not re-sort the table.
        push_cmd(CMD_UPDATE, 64'h5, '1, 5'd1);
        push_cmd(CMD_READ, '0, '0, 5'd1);
        push_cmd(CMD_DELETE, '0, '0, 5'd3);
        push_cmd(CMD_DELETE, '0, '0, 5'd0);
        push_cmd(CMD_DELETE, '0, '0, 5'd31);
        push_cmd(3'd5, '1, '1, 5'd31);
        push_cmd(3'd6, {$urandom, $urandom}, $urandom, 5'd2);
        push_cmd(3'd7, '0, '0, 5'd0);
        push_cmd(CMD_READ, '0, '0, 5'd1);

        // Random part in segments that fill, drain or mix the table.
        random_left = RANDOM_ITEMS;
        while (random_left > 0) begin
            seg_kind = $urandom_range(0, 2);
            seg_len = $urandom_range(20, 80);
            for (n = 0; n < seg_len && random_left > 0; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    op = CMD_W'($urandom_range(5, 7));
                end else if (seg_kind == 0) begin
                    if (roll < 60)
                        op = CMD_INSERT;
                    else if (roll < 72)
                        op = CMD_FIND;
                    else if (roll < 84)
                        op = CMD_READ;
                    else if (roll < 92)
                        op = CMD_UPDATE;
                    else
                        op = CMD_DELETE;
                end else if (seg_kind == 1) begin
                    if (roll < 15)
                        op = CMD_INSERT;
                    else if (roll < 30)
                        op = CMD_FIND;
                    else if (roll < 45)
                        op = CMD_READ;
                    else if (roll < 55)
                        op = CMD_UPDATE;
                    else
                        op = CMD_DELETE;
                end else begin
                    case ($urandom_range(0, 4))
                        0: op = CMD_INSERT;
                        1: op = CMD_DELETE;
                        2: op = CMD_UPDATE;
                        3: op = CMD_FIND;
                        default: op = CMD_READ;
                    endcase
                end
                push_cmd(op, pick_key(), pick_payload(), pick_pos());
                random_left--;
            end
        end
        total_items = pending_cmds.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted < total_items)
            @(posedge aclk);
        while (expected_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && expected_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sorted_key_table_core.f @@
rtl/core/skt_pkg.sv
rtl/core/skt_mem.sv
rtl/core/sorted_key_table_core.sv
tb/sv/tb.sv
